// ===== sv/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// No dependencies; the core and ffha_ctrl import this package.
package ffha_pkg;

  localparam int FW = 13;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_CHK,
    ST_A_W2,
    ST_Q_RD,
    ST_R_HDR,
    ST_R_HEADM,
    ST_R_WALK,
    ST_R_SUCC,
    ST_R_PREV
  } state_t;

  typedef struct packed {
    logic          fin;
    logic [FW-1:0] granted;
    logic          ok;
    logic [FW-1:0] size;
  } result_t;

  localparam logic [FW-1:0] HEAP_BYTES_RST = 13'd4096;

endpackage

// ===== sv/ffha_in_if.sv =====
// Command channel interface of the heap allocator.
// Depends on nothing but the fixed field widths.
interface ffha_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [12:0] request_size;
  logic [12:0] user_offset;
  modport source (output valid, command, request_size, user_offset, input ready);
  modport sink (input valid, command, request_size, user_offset, output ready);
endinterface

// ===== sv/ffha_out_if.sv =====
// Result channel interface of the heap allocator.
// Depends on nothing but the fixed field widths.
interface ffha_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] granted_offset;
  logic        success;
  logic [12:0] block_size;
  modport source (output valid, granted_offset, success, block_size, input ready);
  modport sink (input valid, granted_offset, success, block_size, output ready);
endinterface

// ===== sv/first_fit_heap_allocator_core.sv =====
// First-fit free-list heap allocator with coalescing; top level.
// Allocate and release walk the free list one free block at a time through the single read port.
// One command is in flight at a time; the result register frees the input side.
// Reset is synchronous; ST_INIT then makes the heap one free block of clamped heap_bytes.
module first_fit_heap_allocator_core #(
  parameter int HEAP_MAX_BYTES = 4096,
  parameter int HEADER_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  ffha_in_if.sink     in_chan,
  ffha_out_if.source  out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ffha_pkg::*;

  localparam int AW = $clog2(HEAP_MAX_BYTES);

  logic [FW-1:0] heap_bytes_r;
  logic out_valid_r;
  logic [FW-1:0] out_granted_r, out_size_r;
  logic out_success_r;
  logic busy, start;
  result_t res;
  logic [FW-1:0] rd_size, rd_link, size_wdata, link_wdata;
  logic [AW-1:0] raddr, size_waddr, link_waddr;
  logic size_we, link_we;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(32 - FW){1'b0}}, heap_bytes_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_bytes_r <= HEAP_BYTES_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      heap_bytes_r <= cfg_pwdata[FW-1:0];
    end
  end

  assign in_chan.ready = !busy && rst_n && (!out_valid_r || out_chan.ready);
  assign start = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res.fin) begin
      out_granted_r <= res.granted;
      out_success_r <= res.ok;
      out_size_r <= res.size;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.granted_offset = out_granted_r;
  assign out_chan.success = out_success_r;
  assign out_chan.block_size = out_size_r;

  ffha_ctrl #(
    .HEAP_MAX_BYTES(HEAP_MAX_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .cmd(cmd_t'(in_chan.command)),
    .req_size(in_chan.request_size),
    .uoff(in_chan.user_offset),
    .heap_bytes(heap_bytes_r),
    .busy(busy),
    .rd_size(rd_size),
    .rd_link(rd_link),
    .raddr(raddr),
    .size_we(size_we),
    .size_waddr(size_waddr),
    .size_wdata(size_wdata),
    .link_we(link_we),
    .link_waddr(link_waddr),
    .link_wdata(link_wdata),
    .res(res)
  );

  ffha_ram #(.AW(AW), .DW(FW)) u_size_ram (
    .clk(clk),
    .we(size_we),
    .waddr(size_waddr),
    .wdata(size_wdata),
    .raddr(raddr),
    .rdata(rd_size)
  );

  ffha_ram #(.AW(AW), .DW(FW)) u_link_ram (
    .clk(clk),
    .we(link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(raddr),
    .rdata(rd_link)
  );

endmodule

// ===== sv/ffha_ram.sv =====
// Single-port-write, single-port-read synchronous memory with registered read data.
// Used for the block size store and the next link store.
module ffha_ram #(
  parameter int AW = 12,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ffha_ctrl.sv =====
// Command sequencer: walks the free list through the two header stores.
// Depends on ffha_pkg; drives the ports of two ffha_ram instances.
module ffha_ctrl #(
  parameter int HEAP_MAX_BYTES = 4096,
  parameter int HEADER_BYTES = 8,
  parameter int AW = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  ffha_pkg::cmd_t         cmd,
  input  logic [12:0]            req_size,
  input  logic [12:0]            uoff,
  input  logic [12:0]            heap_bytes,
  output logic                   busy,
  input  logic [12:0]            rd_size,
  input  logic [12:0]            rd_link,
  output logic [AW-1:0]          raddr,
  output logic                   size_we,
  output logic [AW-1:0]          size_waddr,
  output logic [12:0]            size_wdata,
  output logic                   link_we,
  output logic [AW-1:0]          link_waddr,
  output logic [12:0]            link_wdata,
  output ffha_pkg::result_t      res
);
  import ffha_pkg::*;

  localparam int VW = ((AW > FW) ? AW : FW) + 2;
  localparam logic [VW-1:0] MAXV = VW'(HEAP_MAX_BYTES);
  localparam logic [VW-1:0] HDRV = VW'(HEADER_BYTES);
  localparam logic [VW-1:0] FHDR = VW'(2 * HEADER_BYTES);

  function automatic logic has_next(input logic [VW-1:0] x, input logic [VW-1:0] n);
    has_next = (n > x) && (n < MAXV);
  endfunction

  state_t state_r, state_nxt;
  logic [VW-1:0] need_r, need_nxt, cur_r, cur_nxt, prev_r, prev_nxt;
  logic [VW-1:0] blk_r, blk_nxt, total_r, total_nxt, end_r, end_nxt;
  logic [VW-1:0] head_r, head_nxt, psize_r, psize_nxt;
  logic [VW-1:0] given_r, given_nxt, plink_r, plink_nxt;
  logic [VW-1:0] bsize_r, bsize_nxt, blink_r, blink_nxt;
  logic at_head_r, at_head_nxt, plink_we_r, plink_we_nxt, empty_r, empty_nxt;

  logic [VW-1:0] sz_v, ln_v, hb_v, clamp_v, rem_v, nw_v, u_v, b_v, tot_v;
  logic a_fits, a_hn, a_split, w_hs, w_more, w_dbl, w_mrg, off_bad;

  assign sz_v = VW'(rd_size);
  assign ln_v = VW'(rd_link);
  assign hb_v = VW'(heap_bytes);
  assign clamp_v = (hb_v < FHDR) ? FHDR : ((hb_v > MAXV) ? MAXV : hb_v);
  assign rem_v = sz_v - need_r;
  assign nw_v = cur_r + need_r;
  assign a_fits = sz_v >= need_r;
  assign a_hn = has_next(cur_r, ln_v);
  assign a_split = (rem_v >= FHDR) && (nw_v < MAXV);
  assign w_hs = has_next(prev_r, ln_v);
  assign w_more = w_hs && (ln_v < blk_r);
  assign w_dbl = w_hs && (ln_v == blk_r);
  assign w_mrg = w_hs && (end_r == ln_v);
  assign u_v = VW'(uoff);
  assign b_v = u_v - HDRV;
  assign off_bad = (u_v < HDRV) || (b_v >= MAXV);
  assign tot_v = VW'(sz_v[FW-1:0]) + HDRV;
  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      head_r  <= '0;
      empty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      empty_r <= empty_nxt;
    end
    need_r <= need_nxt;
    cur_r <= cur_nxt;
    prev_r <= prev_nxt;
    blk_r <= blk_nxt;
    total_r <= total_nxt;
    end_r <= end_nxt;
    psize_r <= psize_nxt;
    given_r <= given_nxt;
    plink_r <= plink_nxt;
    bsize_r <= bsize_nxt;
    blink_r <= blink_nxt;
    at_head_r <= at_head_nxt;
    plink_we_r <= plink_we_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_ALLOC: state_nxt = empty_r ? ST_IDLE : ST_A_CHK;
            CMD_RELEASE: state_nxt = off_bad ? ST_IDLE : ST_R_HDR;
            CMD_QUERY: state_nxt = off_bad ? ST_IDLE : ST_Q_RD;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_A_CHK: begin
        if (a_fits) state_nxt = ST_A_W2;
        else if (!a_hn) state_nxt = ST_IDLE;
      end
      ST_A_W2: state_nxt = ST_IDLE;
      ST_Q_RD: state_nxt = ST_IDLE;
      ST_R_HDR: begin
        if (empty_r || blk_r == head_r) state_nxt = ST_IDLE;
        else if (blk_r < head_r) begin
          state_nxt = ((blk_r + tot_v) == head_r) ? ST_R_HEADM : ST_IDLE;
        end else state_nxt = ST_R_WALK;
      end
      ST_R_HEADM: state_nxt = ST_IDLE;
      ST_R_WALK: begin
        if (w_more) state_nxt = ST_R_WALK;
        else if (w_dbl) state_nxt = ST_IDLE;
        else if (w_mrg) state_nxt = ST_R_SUCC;
        else state_nxt = ST_R_PREV;
      end
      ST_R_SUCC: state_nxt = ST_R_PREV;
      ST_R_PREV: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    need_nxt = need_r;
    cur_nxt = cur_r;
    prev_nxt = prev_r;
    blk_nxt = blk_r;
    total_nxt = total_r;
    end_nxt = end_r;
    head_nxt = head_r;
    psize_nxt = psize_r;
    given_nxt = given_r;
    plink_nxt = plink_r;
    bsize_nxt = bsize_r;
    blink_nxt = blink_r;
    at_head_nxt = at_head_r;
    plink_we_nxt = plink_we_r;
    empty_nxt = empty_r;
    raddr = '0;
    size_we = 1'b0;
    size_waddr = '0;
    size_wdata = '0;
    link_we = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    res = '0;
    case (state_r)
      ST_INIT: begin
        size_we = 1'b1;
        size_wdata = FW'(clamp_v);
        link_we = 1'b1;
        head_nxt = '0;
        empty_nxt = 1'b0;
      end
      ST_IDLE: begin
        blk_nxt = b_v;
        raddr = AW'(b_v);
        if (start) begin
          case (cmd)
            CMD_RESTART: begin
              size_we = 1'b1;
              size_wdata = FW'(clamp_v);
              link_we = 1'b1;
              head_nxt = '0;
              empty_nxt = 1'b0;
              res.fin = 1'b1;
              res.ok = 1'b1;
            end
            CMD_ALLOC: begin
              need_nxt = VW'(req_size) + HDRV;
              cur_nxt = head_r;
              at_head_nxt = 1'b1;
              plink_we_nxt = 1'b0;
              raddr = AW'(head_r);
              res.fin = empty_r;
            end
            default: res.fin = off_bad;
          endcase
        end
      end
      ST_A_CHK: begin
        if (!a_fits) begin
          if (!a_hn) res.fin = 1'b1;
          else begin
            prev_nxt = cur_r;
            cur_nxt = ln_v;
            at_head_nxt = 1'b0;
            raddr = AW'(ln_v);
          end
        end else if (a_split) begin
          size_we = 1'b1;
          size_waddr = AW'(nw_v);
          size_wdata = FW'(rem_v);
          link_we = 1'b1;
          link_waddr = AW'(nw_v);
          link_wdata = FW'(a_hn ? ln_v : nw_v);
          given_nxt = need_r - HDRV;
          if (at_head_r) head_nxt = nw_v;
          else begin
            plink_nxt = nw_v;
            plink_we_nxt = 1'b1;
          end
        end else begin
          given_nxt = sz_v - HDRV;
          if (at_head_r) begin
            if (a_hn) head_nxt = ln_v;
            else empty_nxt = 1'b1;
          end else begin
            plink_nxt = a_hn ? ln_v : prev_r;
            plink_we_nxt = 1'b1;
          end
        end
      end
      ST_A_W2: begin
        size_we = 1'b1;
        size_waddr = AW'(cur_r);
        size_wdata = FW'(given_r);
        link_we = plink_we_r;
        link_waddr = AW'(prev_r);
        link_wdata = FW'(plink_r);
        res.fin = 1'b1;
        res.ok = 1'b1;
        res.granted = FW'(cur_r + HDRV);
        res.size = FW'(given_r);
      end
      ST_Q_RD: begin
        res.fin = 1'b1;
        res.ok = 1'b1;
        res.size = rd_size;
      end
      ST_R_HDR: begin
        total_nxt = tot_v;
        end_nxt = blk_r + tot_v;
        size_waddr = AW'(blk_r);
        size_wdata = FW'(tot_v);
        link_waddr = AW'(blk_r);
        if (empty_r) begin
          size_we = 1'b1;
          link_we = 1'b1;
          link_wdata = FW'(blk_r);
          head_nxt = blk_r;
          empty_nxt = 1'b0;
          res.fin = 1'b1;
          res.ok = 1'b1;
        end else if (blk_r == head_r) begin
          res.fin = 1'b1;
        end else if (blk_r < head_r) begin
          raddr = AW'(head_r);
          if ((blk_r + tot_v) != head_r) begin
            size_we = 1'b1;
            link_we = 1'b1;
            link_wdata = FW'(head_r);
            head_nxt = blk_r;
            res.fin = 1'b1;
            res.ok = 1'b1;
          end
        end else begin
          prev_nxt = head_r;
          raddr = AW'(head_r);
        end
      end
      ST_R_HEADM: begin
        size_we = 1'b1;
        size_waddr = AW'(blk_r);
        size_wdata = FW'(total_r + sz_v);
        link_we = 1'b1;
        link_waddr = AW'(blk_r);
        link_wdata = FW'(has_next(head_r, ln_v) ? ln_v : blk_r);
        head_nxt = blk_r;
        res.fin = 1'b1;
        res.ok = 1'b1;
      end
      ST_R_WALK: begin
        if (w_more) begin
          prev_nxt = ln_v;
          raddr = AW'(ln_v);
        end else if (w_dbl) begin
          res.fin = 1'b1;
        end else begin
          psize_nxt = sz_v;
          if (w_mrg) begin
            cur_nxt = ln_v;
            raddr = AW'(ln_v);
          end else begin
            bsize_nxt = total_r;
            blink_nxt = w_hs ? ln_v : blk_r;
            size_we = 1'b1;
            size_waddr = AW'(blk_r);
            size_wdata = FW'(total_r);
            link_we = 1'b1;
            link_waddr = AW'(blk_r);
            link_wdata = FW'(w_hs ? ln_v : blk_r);
          end
        end
      end
      ST_R_SUCC: begin
        bsize_nxt = VW'(FW'(total_r + sz_v));
        blink_nxt = has_next(cur_r, ln_v) ? ln_v : blk_r;
        size_we = 1'b1;
        size_waddr = AW'(blk_r);
        size_wdata = FW'(total_r + sz_v);
        link_we = 1'b1;
        link_waddr = AW'(blk_r);
        link_wdata = FW'(has_next(cur_r, ln_v) ? ln_v : blk_r);
      end
      ST_R_PREV: begin
        link_we = 1'b1;
        link_waddr = AW'(prev_r);
        if ((prev_r + psize_r) == blk_r) begin
          size_we = 1'b1;
          size_waddr = AW'(prev_r);
          size_wdata = FW'(psize_r + bsize_r);
          link_wdata = FW'(has_next(blk_r, blink_r) ? blink_r : prev_r);
        end else begin
          link_wdata = FW'(blk_r);
        end
        res.fin = 1'b1;
        res.ok = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
